// ----- rtl/core/sha1sh_pkg.sv -----
// Package: shared types, constants and round functions of the SHA-1 stream hasher.
`timescale 1ns / 1ps
`default_nettype none

package sha1sh_pkg;

    localparam int WordW    = 32;
    localparam int NumChain = 5;
    localparam int NumBlock = 16;
    localparam int CountW   = 64;
    localparam int RoundW   = 7;
    localparam int IdxW     = 3;
    localparam int PosW     = 6;

    typedef logic [WordW-1:0] word_t;

    localparam word_t ShaIv [NumChain] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t RoundK [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    localparam logic [7:0]        Pad80      = 8'h80;
    localparam logic [PosW-1:0]   PosLast    = 6'd63;
    localparam logic [PosW-1:0]   PosLenPos  = 6'd56;
    localparam logic [RoundW-1:0] RoundLast  = 7'd79;
    localparam logic [IdxW-1:0]   WordLast   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMPRESS,
        ST_FOLD,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_PAD80,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    // controller -> datapath
    typedef struct packed {
        logic            byte_wr;
        byte_src_t       byte_src;
        logic            save_len;
        logic            round_en;
        logic            fold;
        logic            restart;
        logic [IdxW-1:0] word_sel;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [PosW-1:0] byte_pos;
        logic            rounds_last;
    } dp_stat_t;

    // round group: 0..19, 20..39, 40..59, 60..79
    function automatic logic [1:0] round_group(input logic [RoundW-1:0] t);
        logic [1:0] g;
        if (t < 7'd20)
            g = 2'd0;
        else if (t < 7'd40)
            g = 2'd1;
        else if (t < 7'd60)
            g = 2'd2;
        else
            g = 2'd3;
        return g;
    endfunction

    function automatic word_t round_f(input logic [1:0] g, input word_t b,
                                      input word_t c, input word_t d);
        word_t f;
        case (g)
            2'd0:    f = d ^ (b & (c ^ d));
            2'd2:    f = (b & c) | (d & (b | c));
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sha1_stream_hasher.sv -----
// Absorb: each item adds one byte; the byte that fills a 64-byte block starts a
// compression (80 rounds, one per cycle, plus the chaining add) in the datapath,
// during which intake stalls. Finish: pad bytes 1 per cycle between compressions
// (9 to 72), a pause before the length, one or two compressions, 5 digest items
// 1/cycle unstalled. rst_n (async, low) restores IV.
// Top level: SHA-1 stream hasher, controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

module sha1_stream_hasher
    import sha1sh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // message channel
    input  wire logic        msg_valid,
    output logic             msg_stall,
    input  wire logic        mode,
    input  wire logic [7:0]  data_byte,
    // digest channel
    output logic             dig_valid,
    input  wire logic        dig_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    // The message block is a 512-bit shift line: each byte enters at the bottom of
    // the last word and everything moves up one byte, so after 64 bytes word 0
    // holds the first four bytes. During the rounds the same line shifts by words,
    // with the expanded schedule word entering at the last word, so W[t] is always word 0.

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sha1sh_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_valid  (msg_valid),
        .msg_stall  (msg_stall),
        .mode       (mode),
        .dig_valid  (dig_valid),
        .dig_stall  (dig_stall),
        .word_index (word_index),
        .last_word  (last_word),
        .stat       (stat),
        .cmd        (cmd)
    );

    // datapath: chaining words, bit count, length copy used by the padding
    sha1sh_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .stat        (stat),
        .digest_word (digest_word)
    );

endmodule

`default_nettype wire

// ----- rtl/core/sha1sh_dp.sv -----
// Datapath: block shift buffer, bit count, round registers and chaining words.
`timescale 1ns / 1ps
`default_nettype none

module sha1sh_dp
    import sha1sh_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] data_byte,
    input  wire dp_cmd_t    cmd,
    output dp_stat_t        stat,
    output word_t           digest_word
);

    word_t               chain_reg [NumChain];
    word_t               blk_reg   [NumBlock];
    logic [CountW-1:0]   count_reg;
    logic [CountW-1:0]   len_reg;
    logic [RoundW-1:0]   round_reg;
    word_t               a_reg, b_reg, c_reg, d_reg, e_reg;

    logic [7:0]          byte_val;
    logic                block_full;
    word_t               sched_x;
    word_t               sched_new;
    word_t               t_val;
    logic [1:0]          grp;

    always_comb
    begin
        case (cmd.byte_src)
            SRC_DATA:  byte_val = data_byte;
            SRC_PAD80: byte_val = Pad80;
            SRC_LEN:   byte_val = len_reg[CountW-1 -: 8];
            default:   byte_val = 8'h00;
        endcase
    end

    assign block_full = cmd.byte_wr && (count_reg[8:3] == PosLast);

    // message schedule W[t+16] from the 16-word window
    assign sched_x   = blk_reg[13] ^ blk_reg[8] ^ blk_reg[2] ^ blk_reg[0];
    assign sched_new = {sched_x[WordW-2:0], sched_x[WordW-1]};

    assign grp   = round_group(round_reg);
    assign t_val = {a_reg[26:0], a_reg[31:27]} + round_f(grp, b_reg, c_reg, d_reg)
                 + e_reg + RoundK[grp] + blk_reg[0];

    // control-like state: chaining words, count and round counter carry reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NumChain; i++)
            begin
                chain_reg[i] <= ShaIv[i];
            end
            count_reg <= '0;
            round_reg <= '0;
        end else begin
            if (cmd.restart) begin
                for (int i = 0; i < NumChain; i++)
                begin
                    chain_reg[i] <= ShaIv[i];
                end
                count_reg <= '0;
            end else begin
                if (cmd.fold) begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                    chain_reg[4] <= chain_reg[4] + e_reg;
                end
                if (cmd.byte_wr)
                    count_reg <= count_reg + CountW'(8);
            end
            if (block_full)
                round_reg <= '0;
            else if (cmd.round_en)
                round_reg <= round_reg + RoundW'(1);
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.byte_wr) begin
            for (int i = 0; i < NumBlock - 1; i++)
            begin
                blk_reg[i] <= {blk_reg[i][23:0], blk_reg[i+1][31:24]};
            end
            blk_reg[NumBlock-1] <= {blk_reg[NumBlock-1][23:0], byte_val};
        end else if (cmd.round_en) begin
            for (int i = 0; i < NumBlock - 1; i++)
            begin
                blk_reg[i] <= blk_reg[i+1];
            end
            blk_reg[NumBlock-1] <= sched_new;
        end

        if (cmd.save_len)
            len_reg <= count_reg;
        else if (cmd.byte_wr && (cmd.byte_src == SRC_LEN))
            len_reg <= {len_reg[CountW-9:0], 8'h00};

        if (block_full) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end else if (cmd.round_en) begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    assign stat.byte_pos    = count_reg[8:3];
    assign stat.rounds_last = (round_reg == RoundLast);

    always_comb
    begin
        case (cmd.word_sel)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/sha1sh_ctrl.sv -----
// Controller: state machine sequencing intake, padding, rounds and digest output.
`timescale 1ns / 1ps
`default_nettype none

module sha1sh_ctrl
    import sha1sh_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            msg_valid,
    output logic                 msg_stall,
    input  wire logic            mode,
    output logic                 dig_valid,
    input  wire logic            dig_stall,
    output logic [IdxW-1:0]      word_index,
    output logic                 last_word,
    input  wire dp_stat_t        stat,
    output dp_cmd_t              cmd
);

    state_t          state_reg, state_next;
    state_t          resume_reg, resume_next;
    logic [IdxW-1:0] idx_reg, idx_next;
    logic            pos_last;

    assign pos_last = (stat.byte_pos == PosLast);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            resume_reg <= ST_IDLE;
            idx_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
            idx_reg    <= idx_next;
        end
    end

    // next state
    always_comb
    begin
        state_next  = state_reg;
        resume_next = resume_reg;
        idx_next    = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid) begin
                    if (pos_last) begin
                        state_next  = ST_COMPRESS;
                        resume_next = mode ? ST_PAD_ZERO : ST_IDLE;
                    end else if (mode) begin
                        state_next = ST_PAD_ZERO;
                    end
                end
            end
            ST_COMPRESS:
            begin
                if (stat.rounds_last)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                state_next = resume_reg;
            end
            ST_PAD_ZERO:
            begin
                if (stat.byte_pos == PosLenPos) begin
                    state_next = ST_PAD_LEN;
                end else if (pos_last) begin
                    state_next  = ST_COMPRESS;
                    resume_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_LEN:
            begin
                if (pos_last) begin
                    state_next  = ST_COMPRESS;
                    resume_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!dig_stall) begin
                    if (idx_reg == WordLast) begin
                        state_next = ST_IDLE;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + IdxW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath commands
    always_comb
    begin
        cmd          = '0;
        cmd.byte_src = SRC_DATA;
        cmd.word_sel = idx_reg;
        msg_stall    = 1'b1;
        dig_valid    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                msg_stall = 1'b0;
                if (msg_valid) begin
                    cmd.byte_wr = 1'b1;
                    if (mode) begin
                        cmd.byte_src = SRC_PAD80;
                        cmd.save_len = 1'b1;
                    end
                end
            end
            ST_COMPRESS:
            begin
                cmd.round_en = 1'b1;
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
            end
            ST_PAD_ZERO:
            begin
                if (stat.byte_pos != PosLenPos) begin
                    cmd.byte_wr  = 1'b1;
                    cmd.byte_src = SRC_ZERO;
                end
            end
            ST_PAD_LEN:
            begin
                cmd.byte_wr  = 1'b1;
                cmd.byte_src = SRC_LEN;
            end
            ST_EMIT:
            begin
                dig_valid = 1'b1;
                if (!dig_stall && (idx_reg == WordLast))
                    cmd.restart = 1'b1;
            end
            default:
            begin
                msg_stall = 1'b1;
            end
        endcase
    end

    assign word_index = idx_reg;
    assign last_word  = (idx_reg == WordLast);

endmodule

`default_nettype wire

// ----- rtl/core/sha1sh_checker.sv -----
// Checker: port-level properties of the SHA-1 stream hasher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sha1sh_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        msg_valid,
    input wire logic        msg_stall,
    input wire logic        mode,
    input wire logic        dig_valid,
    input wire logic        dig_stall,
    input wire logic [31:0] digest_word,
    input wire logic [2:0]  word_index,
    input wire logic        last_word
);

    // no message item is taken while a digest is going out
    a_no_intake_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> msg_stall)
        else $error("message item accepted during digest output");

    // a finish item blocks intake on the next cycle
    a_finish_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_valid && !msg_stall && mode) |=> msg_stall)
        else $error("intake open right after a finish item");

    // digest words follow one another in order
    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        (dig_valid && !dig_stall && !last_word) |=>
            (dig_valid && (word_index == $past(word_index) + 3'd1)))
        else $error("digest word sequence broken");

    // nothing more after the final word
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (dig_valid && !dig_stall && last_word) |=> !dig_valid)
        else $error("digest item after the final word");

    // a stalled digest item holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (dig_valid && dig_stall) |=> (dig_valid && $stable(digest_word)
            && $stable(word_index)))
        else $error("stalled digest item changed");

endmodule

bind sha1_stream_hasher sha1sh_checker u_sha1sh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .msg_valid   (msg_valid),
    .msg_stall   (msg_stall),
    .mode        (mode),
    .dig_valid   (dig_valid),
    .dig_stall   (dig_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
);

`default_nettype wire

// ----- verif/tb_sha1_stream_hasher.sv -----
// Testbench for sha1_stream_hasher: byte-stream SHA-1 digests checked against a local model.
`timescale 1ns / 1ps

module tb_sha1_stream_hasher;

    // item modes on the message channel
    localparam logic MODE_ABSORB = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    localparam int DIGEST_WORDS = 5;
    localparam int RANDOM_ITEMS = 220;
    // no idling on either side once the backlog drops to this many items
    localparam int QUIET_ITEMS  = 30;
    // worst finish: 72 pad bytes, two compressions, five words, stalls
    localparam int DRAIN_CYCLES = 300;
    // cycles without any handshake before the run is declared hung
    localparam int HANG_LIMIT   = 3000;

    typedef struct packed {
        logic       mode;
        logic [7:0] data;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  idx;
        logic        last;
    } digest_rec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        msg_valid = 1'b0;
    logic        msg_stall;
    logic        mode = MODE_ABSORB;
    logic [7:0]  data_byte = 8'h00;
    logic        dig_valid;
    logic        dig_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha1_stream_hasher i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg_valid   (msg_valid),
        .msg_stall   (msg_stall),
        .mode        (mode),
        .data_byte   (data_byte),
        .dig_valid   (dig_valid),
        .dig_stall   (dig_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Hash model: its own chaining words, block buffer and bit count.
    // ------------------------------------------------------------------
    logic [31:0] hash_chain [DIGEST_WORDS];
    logic [31:0] hash_blk [16];
    logic [63:0] hash_bits;

    msg_item_t   pending_q [$];
    digest_rec_t digest_q [$];

    int n_items_in;
    int n_finishes;
    int n_words_checked;
    int n_compressions;
    int n_errors;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic logic [31:0] round_const(input int t);
        logic [31:0] k;
        if (t < 20)
            k = 32'h5A827999;
        else if (t < 40)
            k = 32'h6ED9EBA1;
        else if (t < 60)
            k = 32'h8F1BBCDC;
        else
            k = 32'hCA62C1D6;
        return k;
    endfunction

    task automatic hash_restart();
        hash_chain[0] = 32'h67452301;
        hash_chain[1] = 32'hEFCDAB89;
        hash_chain[2] = 32'h98BADCFE;
        hash_chain[3] = 32'h10325476;
        hash_chain[4] = 32'hC3D2E1F0;
        for (int i = 0; i < 16; i++)
            hash_blk[i] = 32'h0;
        hash_bits = 64'd0;
    endtask

    // 80 rounds; the schedule overwrites the block buffer in place
    task automatic hash_compress();
        logic [31:0] a, b, c, d, e, f, tmp;
        int j;
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        e = hash_chain[4];
        for (int t = 0; t < 80; t++)
        begin
            j = t % 16;
            if (t >= 16)
                hash_blk[j] = rotl32(hash_blk[(t - 3) % 16] ^ hash_blk[(t - 8) % 16] ^
                                     hash_blk[(t - 14) % 16] ^ hash_blk[j], 1);
            if (t < 20)
                f = d ^ (b & (c ^ d));
            else if (t < 40 || t >= 60)
                f = b ^ c ^ d;
            else
                f = (b & c) | (d & (b | c));
            tmp = rotl32(a, 5) + f + e + round_const(t) + hash_blk[j];
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = tmp;
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
        hash_chain[4] += e;
        n_compressions++;
    endtask

    // byte goes into the word picked by count bits 8..5, shifting the old contents up
    task automatic hash_take_byte(input logic [7:0] b);
        int unsigned w;
        w = hash_bits[8:5];
        hash_blk[w] = {hash_blk[w][23:0], b};
        hash_bits += 64'd8;
        if (hash_bits[8:0] == 9'd0)
            hash_compress();
    endtask

    // update the model for one accepted item and queue any digest words it yields
    task automatic hash_apply_item(input logic m, input logic [7:0] b);
        logic [63:0] msg_bits;
        digest_rec_t rec;
        if (m == MODE_ABSORB)
        begin
            hash_take_byte(b);
        end
        else
        begin
            msg_bits = hash_bits;
            hash_take_byte(8'h80);
            while (hash_bits[8:0] != 9'd448)
                hash_take_byte(8'h00);
            for (int i = 7; i >= 0; i--)
                hash_take_byte(msg_bits[8 * i +: 8]);
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                rec.value = hash_chain[i];
                rec.idx   = 3'(i);
                rec.last  = (i == DIGEST_WORDS - 1);
                digest_q.push_back(rec);
            end
            n_finishes++;
            hash_restart();
        end
    endtask

    // ------------------------------------------------------------------
    // Message driver. Idle bursts start at random after an accepted item while
    // the backlog exceeds QUIET_ITEMS; the decision never looks at msg_stall. A
    // stalled item holds its payload untouched.
    // ------------------------------------------------------------------
    int   gap_left = 0;
    logic quiet_tail = 1'b0;

    always @(posedge clk)
    begin : drive_msg
        msg_item_t nxt;
        if (rst_n && !(msg_valid && msg_stall))
        begin
            if (msg_valid)
            begin
                hash_apply_item(mode, data_byte);
                n_items_in++;
            end
            quiet_tail <= (pending_q.size() <= QUIET_ITEMS);
            if (gap_left > 0)
            begin
                gap_left--;
                msg_valid <= 1'b0;
            end
            else if (msg_valid && pending_q.size() > QUIET_ITEMS &&
                     $urandom_range(0, 3) == 0)
            begin
                gap_left = $urandom_range(1, 5) - 1;
                msg_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                nxt = pending_q.pop_front();
                mode      <= nxt.mode;
                data_byte <= nxt.data;
                msg_valid <= 1'b1;
            end
            else
            begin
                msg_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Digest monitor: random stall bursts, field-by-field compare against
    // the oldest queued word.
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk)
    begin : watch_digest
        digest_rec_t want;
        if (rst_n)
        begin
            if (dig_valid && !dig_stall)
            begin
                if (digest_q.size() == 0)
                begin
                    $error("digest word %h (index %0d) with no digest pending",
                           digest_word, word_index);
                    n_errors++;
                end
                else
                begin
                    want = digest_q.pop_front();
                    n_words_checked++;
                    if (digest_word !== want.value)
                    begin
                        $error("digest_word: expected %h, got %h", want.value, digest_word);
                        n_errors++;
                    end
                    if (word_index !== want.idx)
                    begin
                        $error("word_index: expected %0d, got %0d", want.idx, word_index);
                        n_errors++;
                    end
                    if (last_word !== want.last)
                    begin
                        $error("last_word: expected %0b, got %0b", want.last, last_word);
                        n_errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                dig_stall <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                dig_stall <= 1'b1;
            end
            else
            begin
                dig_stall <= 1'b0;
            end
        end
    end

    // hang detection: counts cycles with no handshake on either channel
    int hang_cycles = 0;

    always @(posedge clk)
    begin
        if ((msg_valid && !msg_stall) || (dig_valid && !dig_stall))
            hang_cycles <= 0;
        else
            hang_cycles <= hang_cycles + 1;
        if (hang_cycles >= HANG_LIMIT)
        begin
            $display("no handshake for %0d cycles, %0d digest words outstanding",
                     HANG_LIMIT, digest_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_item(input logic m, input logic [7:0] b);
        msg_item_t it;
        it.mode = m;
        it.data = b;
        pending_q.push_back(it);
    endtask

    // random-content message of the given length, then a finish with a junk byte
    task automatic queue_message(input int len);
        for (int i = 0; i < len; i++)
            queue_item(MODE_ABSORB, 8'($urandom_range(0, 255)));
        queue_item(MODE_FINISH, 8'($urandom_range(0, 255)));
    endtask

    int longest_msg = 0;

    initial
    begin : stimulus
        int len;
        int pick;
        int random_start;

        hash_restart();
        n_items_in = 0;
        n_finishes = 0;
        n_words_checked = 0;
        n_compressions = 0;
        n_errors = 0;

        // empty message, back-to-back; the data byte must be ignored on a finish
        queue_item(MODE_FINISH, 8'hFF);
        queue_item(MODE_FINISH, 8'h00);
        // "abc", a known answer
        queue_item(MODE_ABSORB, 8'h61);
        queue_item(MODE_ABSORB, 8'h62);
        queue_item(MODE_ABSORB, 8'h63);
        queue_item(MODE_FINISH, 8'hA5);
        // byte extremes, five bytes so the last word is partly filled
        queue_item(MODE_ABSORB, 8'h00);
        queue_item(MODE_ABSORB, 8'hFF);
        queue_item(MODE_ABSORB, 8'h80);
        queue_item(MODE_ABSORB, 8'h7F);
        queue_item(MODE_ABSORB, 8'h01);
        queue_item(MODE_FINISH, 8'h5A);
        queue_message(7);

        // Random messages: mostly short, some straddling the one/two block
        // padding boundary and whole-block lengths.
        random_start = pending_q.size();
        while (pending_q.size() - random_start < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
            begin
                case ($urandom_range(0, 7))
                    0: len = 55;
                    1: len = 56;
                    2: len = 57;
                    3: len = 63;
                    4: len = 64;
                    5: len = 65;
                    6: len = 119;
                    default: len = 128;
                endcase
            end
            else if (pick == 2)
                len = 0;
            else
                len = $urandom_range(1, 30);
            if (len > longest_msg)
                longest_msg = len;
            queue_message(len);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || msg_valid)
            @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
        // let any stray extra words show up
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d message items, %0d digests, %0d digest words compared",
                 n_items_in, n_finishes, n_words_checked);
        $display("model ran %0d block compressions, longest random message %0d bytes",
                 n_compressions, longest_msg);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/sha1sh_pkg.sv
rtl/core/sha1sh_dp.sv
rtl/core/sha1sh_ctrl.sv
rtl/core/sha1_stream_hasher.sv
rtl/core/sha1sh_checker.sv
verif/tb_sha1_stream_hasher.sv
